>>> src/lskv_pkg.sv
// lskv_pkg: shared widths, item kinds, status codes and the control structs
// for the linear search key-value table
// no dependencies
package lskv_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KIND_W       = 3;
  localparam int KEY_W        = 32;
  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;

  typedef logic [KIND_W-1:0]          kind_t;
  typedef logic signed [KEY_W-1:0]    key_t;
  typedef logic signed [DATA_W-1:0]   data_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [COUNT_W-1:0]         count_t;

  // item kinds
  localparam kind_t KIND_LOOKUP = 3'd0;
  localparam kind_t KIND_FETCH  = 3'd1;
  localparam kind_t KIND_STORE  = 3'd2;
  localparam kind_t KIND_REMOVE = 3'd3;
  localparam kind_t KIND_CLEAR  = 3'd4;

  // result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_ABSENT = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic search;
    logic shift_start;
    logic shift;
    logic commit;
    logic post;
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic search_done;
    logic shift_done;
    logic hit;
    logic is_remove;
    logic out_free;
  } dp_stat_t;

endpackage

>>> src/lskv_req_if.sv
// lskv_req_if: request channel, one word per item (kind, key, data)
// depends on lskv_pkg
interface lskv_req_if;
  import lskv_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  key_t  key;
  data_t data;

  modport source (output valid, kind, key, data, input ready);
  modport sink   (input valid, kind, key, data, output ready);
endinterface

>>> src/lskv_rsp_if.sv
// lskv_rsp_if: response channel, one word per item
// depends on lskv_pkg
interface lskv_rsp_if;
  import lskv_pkg::*;

  logic    valid;
  logic    ready;
  data_t   value;
  logic    found;
  status_t status;
  count_t  entry_count;

  modport source (output valid, value, found, status, entry_count, input ready);
  modport sink   (input valid, value, found, status, entry_count, output ready);
endinterface

>>> src/lskv_ram.sv
// lskv_ram: generic single write port, single read port ram, registered read
// no dependencies
module lskv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> src/lskv_ctrl.sv
// lskv_ctrl: sequencing state machine for one item at a time
// depends on lskv_pkg
module lskv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lskv_pkg::dp_stat_t stat,
  output lskv_pkg::ctl_cmd_t cmd
);
  import lskv_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_FINISH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.search_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.is_remove && stat.hit) begin
          cmd.shift_start = 1'b1;
          state_next      = S_SHIFT;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

>>> src/lskv_dp.sv
// lskv_dp: key and value rams, search and shift pointers, fill count,
// result and output registers; depends on lskv_pkg and lskv_ram
module lskv_dp #(
  parameter int CAPACITY = lskv_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lskv_pkg::ctl_cmd_t  cmd,
  output lskv_pkg::dp_stat_t  stat,
  input  lskv_pkg::kind_t     kind,
  input  lskv_pkg::key_t      key,
  input  lskv_pkg::data_t     data,
  output logic                out_valid,
  input  logic                out_ready,
  output lskv_pkg::data_t     value,
  output logic                found,
  output lskv_pkg::status_t   status,
  output lskv_pkg::count_t    entry_count
);
  import lskv_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // item registers
  kind_t kind_r;
  key_t  key_r;
  data_t data_r;

  // control registers
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [CW-1:0] issue;
  logic          pend;
  logic          hit;
  logic [CW-1:0] rd_ptr;
  logic          spend;

  // payload registers
  logic [AW-1:0] pend_idx;
  logic [AW-1:0] pos;
  data_t         hval;
  logic [AW-1:0] sidx;
  data_t         res_value;
  logic          res_found;
  status_t       res_status;

  // ram ports
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  key_t          key_rd;
  data_t         val_rd;
  logic          key_we;
  logic          val_we;
  key_t          key_wd;
  data_t         val_wd;

  // commit results
  logic          c_key_we;
  logic          c_val_we;
  logic [AW-1:0] c_addr;
  data_t         c_vwd;
  data_t         c_value;
  logic          c_found;
  status_t       c_status;

  logic issue_live;
  logic shift_live;
  logic match;

  assign issue_live = (issue < fill);
  assign shift_live = (rd_ptr < fill);
  assign match      = pend && (key_rd == key_r);

  assign stat.search_done = match || (!pend && !issue_live);
  assign stat.shift_done  = !spend && !shift_live;
  assign stat.hit         = hit;
  assign stat.is_remove   = (kind_r == KIND_REMOVE);
  assign stat.out_free    = !out_valid || out_ready;

  // table update for the finished item
  always_comb begin
    fill_next = fill;
    c_key_we  = 1'b0;
    c_val_we  = 1'b0;
    c_addr    = pos;
    c_vwd     = data_r;
    c_value   = '0;
    c_found   = 1'b0;
    c_status  = ST_OK;
    case (kind_r)
      KIND_LOOKUP: begin
        c_found = hit;
        if (hit) begin
          c_value = hval;
        end
      end
      KIND_FETCH, KIND_STORE: begin
        if (hit) begin
          c_found = 1'b1;
          if (kind_r == KIND_STORE) begin
            c_val_we = 1'b1;
            c_value  = data_r;
          end else begin
            c_value = hval;
          end
        end else if (fill < CAP) begin
          c_key_we  = 1'b1;
          c_val_we  = 1'b1;
          c_addr    = fill[AW-1:0];
          c_vwd     = (kind_r == KIND_STORE) ? data_r : '0;
          c_value   = (kind_r == KIND_STORE) ? data_r : '0;
          fill_next = fill + CW'(1);
        end else begin
          c_status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          c_found   = 1'b1;
          fill_next = fill - CW'(1);
        end else begin
          c_status = ST_ABSENT;
        end
      end
      KIND_CLEAR: begin
        fill_next = '0;
      end
      default: begin
      end
    endcase
  end

  // ram address and write selection
  always_comb begin
    rd_addr = cmd.shift ? rd_ptr[AW-1:0] : issue[AW-1:0];
    if (cmd.shift && spend) begin
      key_we  = 1'b1;
      val_we  = 1'b1;
      wr_addr = sidx;
      key_wd  = key_rd;
      val_wd  = val_rd;
    end else begin
      key_we  = cmd.commit && c_key_we;
      val_we  = cmd.commit && c_val_we;
      wr_addr = c_addr;
      key_wd  = key_r;
      val_wd  = c_vwd;
    end
  end

  lskv_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk     (clk),
    .we      (key_we),
    .wr_addr (wr_addr),
    .wr_data (key_wd),
    .rd_addr (rd_addr),
    .rd_data (key_rd)
  );

  lskv_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk     (clk),
    .we      (val_we),
    .wr_addr (wr_addr),
    .wr_data (val_wd),
    .rd_addr (rd_addr),
    .rd_data (val_rd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      issue     <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      rd_ptr    <= '0;
      spend     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        issue <= '0;
        pend  <= 1'b0;
        hit   <= 1'b0;
      end
      if (cmd.search) begin
        pend <= issue_live && !match;
        if (issue_live) begin
          issue <= issue + CW'(1);
        end
        if (match) begin
          hit <= 1'b1;
        end
      end
      if (cmd.shift_start) begin
        rd_ptr <= CW'(pos) + CW'(1);
        spend  <= 1'b0;
      end
      if (cmd.shift) begin
        spend <= shift_live;
        if (shift_live) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
      end
      if (cmd.commit) begin
        fill <= fill_next;
      end
      if (cmd.post) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, hit and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      key_r  <= key;
      data_r <= data;
    end
    if (cmd.search) begin
      pend_idx <= issue[AW-1:0];
      if (match) begin
        pos  <= pend_idx;
        hval <= val_rd;
      end
    end
    if (cmd.shift && shift_live) begin
      sidx <= rd_ptr[AW-1:0] - AW'(1);
    end
    if (cmd.commit) begin
      res_value  <= c_value;
      res_found  <= c_found;
      res_status <= c_status;
    end
    if (cmd.post) begin
      value       <= res_value;
      found       <= res_found;
      status      <= res_status;
      entry_count <= COUNT_W'(fill);
    end
  end

`ifndef SYNTHESIS
  // table never holds more than its capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= CAP)
    else $error("fill count above capacity");

  // a remove that hits takes exactly one entry out
  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && kind_r == KIND_REMOVE && hit) |=> fill == $past(fill) - CW'(1))
    else $error("remove did not shrink the table by one");

  // full status only when the table really is full
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && c_status == ST_FULL) |-> (fill == CAP && !hit))
    else $error("full status with room left");

  // a search hit always points inside the filled part
  a_hit_inside: assert property (@(posedge clk) disable iff (rst)
    (cmd.search && match) |-> (CW'(pend_idx) < fill))
    else $error("search hit beyond the last entry");
`endif
endmodule

>>> src/linear_search_key_value_table_core.sv
// Linear search key-value table: one item at a time, unsorted table in two rams.
// The scan reads one entry per cycle and stops at the first match or at the fill count;
// a remove that hits then shifts the later entries down, one entry per cycle.
// The result word is posted once the output register is free; the next word is
// accepted only after that, since the core holds one item at a time.
// Synchronous reset empties the table and drops any pending result word.
module linear_search_key_value_table_core #(
  parameter int CAPACITY = lskv_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  lskv_req_if.sink  req,
  lskv_rsp_if.source rsp
);
  import lskv_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign req.ready = in_ready;

  // sequencer
  lskv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  lskv_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .kind        (req.kind),
    .key         (req.key),
    .data        (req.data),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .value       (rsp.value),
    .found       (rsp.found),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
  );
endmodule

>>> dv/lskv_table_checker.sv
// lskv_table_checker: watches both channels of the key-value table core, keeps its
// own copy of the table and compares every response word, in order, with its prediction
// depends on lskv_pkg, lskv_req_if and lskv_rsp_if
module lskv_table_checker #(
  parameter int DEPTH = lskv_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  lskv_req_if  req,
  lskv_rsp_if  rsp,
  output int   fail_count,
  output int   outstanding,
  output int   words_checked
);
  import lskv_pkg::*;

  typedef struct packed {
    data_t   value;
    logic    found;
    status_t status;
    count_t  entry_count;
  } lookup_result_t;

  // shadow table, insertion order, only entries below table_fill are live
  key_t  table_keys [DEPTH];
  data_t table_vals [DEPTH];
  int    table_fill;

  lookup_result_t pending_results[$];

  // apply one request word to the shadow table and return the response it should give
  function automatic lookup_result_t apply_to_table(kind_t kind, key_t key, data_t data);
    lookup_result_t r;
    int pos;
    r = '0;
    pos = table_fill;
    // scan backwards so the first matching entry wins
    for (int i = table_fill - 1; i >= 0; i--) begin
      if (table_keys[i] == key) pos = i;
    end
    r.found = (pos < table_fill);
    case (kind)
      KIND_LOOKUP: begin
        if (r.found) r.value = table_vals[pos];
      end
      KIND_FETCH, KIND_STORE: begin
        if (r.found) begin
          if (kind == KIND_STORE) table_vals[pos] = data;
          r.value = table_vals[pos];
        end else if (table_fill < DEPTH) begin
          table_keys[table_fill] = key;
          table_vals[table_fill] = (kind == KIND_STORE) ? data : data_t'(0);
          r.value = table_vals[table_fill];
          table_fill++;
        end else begin
          r.status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (r.found) begin
          // close the gap, keeping the order of the later entries
          for (int i = pos; i < table_fill - 1; i++) begin
            table_keys[i] = table_keys[i + 1];
            table_vals[i] = table_vals[i + 1];
          end
          table_fill--;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      KIND_CLEAR: begin
        r.found = 1'b0;
        table_fill = 0;
      end
      default: begin
        r.found = 1'b0;
      end
    endcase
    r.entry_count = table_fill[COUNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // predict on every accepted request word, compare on every accepted response word
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      table_fill = 0;
      pending_results.delete();
      fail_count = 0;
      words_checked = 0;
      outstanding <= 0;
    end else begin
      if (req.valid && req.ready)
        pending_results.push_back(apply_to_table(req.kind, req.key, req.data));
      if (rsp.valid && rsp.ready) begin
        words_checked++;
        if (pending_results.size() == 0) begin
          $error("response word with no request waiting for it");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("value", 64'(want.value), 64'(rsp.value));
          check_field("found", 64'(want.found), 64'(rsp.found));
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("entry_count", 64'(want.entry_count), 64'(rsp.entry_count));
        end
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

>>> dv/linear_search_key_value_table_core_test.sv
// linear_search_key_value_table_core_test: drives request words into the table core
// under several idle mixes and gives the verdict from the checker's failure count
// depends on lskv_pkg, both channel interfaces, the core and lskv_table_checker
module linear_search_key_value_table_core_test;
  import lskv_pkg::*;

  localparam int TABLE_DEPTH     = CAPACITY_DEF;
  localparam int STALL_LIMIT     = 5000;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int DRAIN_CYCLES    = 2 * TABLE_DEPTH + 20;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int POOL_MAX        = 128;

  localparam kind_t KIND_UNUSED_FIRST = 3'd5;
  localparam kind_t KIND_UNUSED_LAST  = 3'd7;

  localparam key_t  KEY_MIN  = 32'h8000_0000;
  localparam key_t  KEY_MAX  = 32'h7fff_ffff;
  localparam key_t  KEY_ZERO = 32'h0000_0000;
  localparam key_t  KEY_ONES = 32'hffff_ffff;
  localparam key_t  KEY_ODD  = 32'h1234_5678;
  localparam data_t DATA_MIN = 32'h8000_0000;
  localparam data_t DATA_MAX = 32'h7fff_ffff;
  localparam data_t DATA_ONES = 32'hffff_ffff;

  logic clk = 1'b0;
  logic rst;

  lskv_req_if req_ch ();
  lskv_rsp_if rsp_ch ();

  int fail_count;
  int results_outstanding;
  int words_checked;

  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_left;
  int holdoff_requests;
  int holdoff_taken;
  int quiet_cycles;
  int words_sent;
  int kind_tally [8];

  key_t key_pool [POOL_MAX];
  int   pool_size;

  linear_search_key_value_table_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lskv_table_checker #(.DEPTH(TABLE_DEPTH)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .fail_count    (fail_count),
    .outstanding   (results_outstanding),
    .words_checked (words_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready  <= 1'b0;
      holdoff_left  <= 0;
      holdoff_taken <= 0;
    end else if (holdoff_taken != holdoff_requests) begin
      rsp_ch.ready  <= 1'b0;
      holdoff_left  <= HOLDOFF_CYCLES - 1;
      holdoff_taken <= holdoff_requests;
    end else if (holdoff_left > 0) begin
      rsp_ch.ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $error("no word moved for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request word after a random gap and wait for it to be taken
  task automatic send_word(kind_t kind, key_t key, data_t data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.key   <= key;
    req_ch.data  <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    words_sent++;
    kind_tally[kind]++;
  endtask

  // stop offering until every predicted response word has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  // fresh set of random keys, sometimes with the extreme keys mixed in
  function automatic void new_key_pool(int n);
    pool_size = n;
    for (int i = 0; i < n; i++) key_pool[i] = $urandom();
    if ($urandom_range(0, 1)) key_pool[$urandom_range(0, n - 1)] = KEY_MIN;
    if ($urandom_range(0, 1)) key_pool[$urandom_range(0, n - 1)] = KEY_MAX;
    if ($urandom_range(0, 3) == 0) key_pool[$urandom_range(0, n - 1)] = KEY_ZERO;
    if ($urandom_range(0, 3) == 0) key_pool[$urandom_range(0, n - 1)] = KEY_ONES;
  endfunction

  function automatic key_t pool_key();
    return key_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  // weighted kind: mostly lookups, inserts and removes, clears and unused kinds rare
  function automatic kind_t random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return KIND_LOOKUP;
    if (r < 45) return KIND_FETCH;
    if (r < 70) return KIND_STORE;
    if (r < 95) return KIND_REMOVE;
    if (r < 97) return KIND_CLEAR;
    return kind_t'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
  endfunction

  task automatic mixed_words(int n);
    for (int i = 0; i < n; i++) send_word(random_kind(), pool_key(), $urandom());
  endtask

  initial begin
    int phase_start;
    int pick;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_LOOKUP;
    req_ch.key = '0;
    req_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_requests = 0;
    words_sent = 0;
    pool_size = 1;
    foreach (kind_tally[k]) kind_tally[k] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, every kind, shifts, misses and clear
    send_word(KIND_LOOKUP, KEY_ZERO, DATA_ONES);
    send_word(KIND_REMOVE, KEY_MAX, DATA_ONES);
    send_word(KIND_STORE, KEY_MIN, DATA_MAX);
    send_word(KIND_FETCH, KEY_MAX, DATA_MIN);
    send_word(KIND_STORE, KEY_ZERO, DATA_MIN);
    send_word(KIND_STORE, KEY_ONES, '0);
    send_word(KIND_LOOKUP, KEY_MIN, '0);
    send_word(KIND_FETCH, KEY_MIN, DATA_ONES);
    send_word(KIND_STORE, KEY_MAX, DATA_ONES);
    send_word(KIND_LOOKUP, KEY_MAX, '0);
    send_word(KIND_REMOVE, KEY_MIN, DATA_MAX);
    send_word(KIND_LOOKUP, KEY_ZERO, '0);
    for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
      send_word(kind_t'(k), KEY_ZERO, DATA_ONES);
    send_word(KIND_REMOVE, KEY_ONES, '0);
    send_word(KIND_REMOVE, KEY_ODD, '0);
    send_word(KIND_CLEAR, KEY_MAX, DATA_MAX);
    send_word(KIND_LOOKUP, KEY_MAX, '0);
    send_word(KIND_FETCH, KEY_ODD, DATA_MAX);
    drain_results();

    // random: phases cycle through the idle mixes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      phase_start = words_sent;

      // long response hold-off while requests keep coming, so the input backs up
      if (ph == 0) begin
        holdoff_requests <= holdoff_requests + 1;
        new_key_pool(6);
        mixed_words(10);
      end

      while (words_sent - phase_start < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          // fill to capacity, push past it, then remove the head and churn
          new_key_pool(TABLE_DEPTH + 8);
          send_word(KIND_CLEAR, $urandom(), $urandom());
          for (int i = 0; i < TABLE_DEPTH + 4; i++)
            send_word($urandom_range(0, 1) ? KIND_STORE : KIND_FETCH, key_pool[i], $urandom());
          send_word(KIND_REMOVE, key_pool[0], $urandom());
          mixed_words(20);
        end else if (pick < 9) begin
          new_key_pool($urandom_range(4, 80));
          mixed_words(40);
        end else begin
          // noise: any kind, any key
          for (int i = 0; i < 12; i++)
            send_word(kind_t'($urandom_range(0, 7)), $urandom(), $urandom());
        end
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words: %0d lookups, %0d fetches, %0d stores, %0d removes, %0d clears",
             words_sent, kind_tally[KIND_LOOKUP], kind_tally[KIND_FETCH],
             kind_tally[KIND_STORE], kind_tally[KIND_REMOVE], kind_tally[KIND_CLEAR]);
    $display("%0d responses checked across four idle mixes, full-table and hold-off runs",
             words_checked);
    if (fail_count == 0 && results_outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> linear_search_key_value_table_core.f
src/lskv_pkg.sv
src/lskv_req_if.sv
src/lskv_rsp_if.sv
src/lskv_ram.sv
src/lskv_ctrl.sv
src/lskv_dp.sv
src/linear_search_key_value_table_core.sv
dv/lskv_table_checker.sv
dv/linear_search_key_value_table_core_test.sv
